[src/lav_pkg.sv]
// Shared types, constants and helper functions of the look-at view matrix unit.
// No dependencies; lav_unit and the top level import this package.
package lav_pkg;

  localparam int COORD_W   = 32;               // Q16.16 coordinates
  localparam int VEC_W     = 64;               // working width of unnormalized vectors
  localparam int AX_W      = 32;               // Q2.30 axis components
  localparam int OFF_W     = 40;               // Q23.16 offsets
  localparam int ROOT_BITS = 31;               // bits of vector length and of quotients
  localparam int Q30_SH    = 30;
  localparam int FIT_W     = 30;               // magnitudes after fitting to [2^29, 2^30)
  // fit and square stages, sqrt steps, numerator stage, divide steps, sign stage
  localparam int UNIT_LAT  = 2 * ROOT_BITS + 7;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [AX_W-1:0]    axis_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OFF_W-1:0]   off_t;

  localparam vec_t   Q30_ONE    = vec_t'(64'sd1073741824);
  localparam vec_t   Q30_HALF   = vec_t'(64'sd536870912);
  localparam vec_t   OFF_MAX    = vec_t'(64'sd549755813887);
  localparam vec_t   OFF_MIN    = vec_t'(-64'sd549755813888);
  localparam coord_t UP_X_RESET = coord_t'(32'sd0);
  localparam coord_t UP_Y_RESET = coord_t'(32'sd65536);
  localparam coord_t UP_Z_RESET = coord_t'(32'sd0);

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2
  } row_e;

  typedef struct packed {
    logic valid;
    logic ok;
  } unit_st_t;

  function automatic logic [VEC_W-1:0] mag64(input vec_t v);
    return v[VEC_W-1] ? (VEC_W)'(-v) : (VEC_W)'(v);
  endfunction

  function automatic logic [5:0] msb_pos(input logic [VEC_W-1:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  // shift so that a value whose top bit is at pos lands in [2^29, 2^30)
  function automatic logic [FIT_W-1:0] fit_mag(input logic [VEC_W-1:0] m,
                                                input logic [5:0] pos);
    logic [VEC_W-1:0] s;
    if (pos >= 6'(FIT_W)) s = m >> (pos - 6'(FIT_W - 1));
    else                  s = m << (6'(FIT_W - 1) - pos);
    return s[FIT_W-1:0];
  endfunction

  function automatic vec_t smul(input axis_t a, input axis_t b);
    return vec_t'(a) * vec_t'(b);
  endfunction

endpackage

[src/lav_ifs.sv]
// Handshake channels of the look-at view matrix unit: configuration, input, result.
// Depends on nothing; widths follow the package constants by value.
interface lav_cfg_if;
  logic               valid;
  logic               ready;
  logic [1:0]         index;
  logic signed [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface lav_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] aim_x;
  logic signed [31:0] aim_y;
  logic signed [31:0] aim_z;
  modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, output ready);
endinterface

interface lav_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic signed [39:0] offset;
  logic               degenerate;
  logic               last_row;
  modport source (output valid, row_index, axis_x, axis_y, axis_z, offset, degenerate,
                  last_row, input ready);
  modport sink   (input valid, row_index, axis_x, axis_y, axis_z, offset, degenerate,
                  last_row, output ready);
endinterface

[src/lav_unit.sv]
// Pipelined vector normalizer: fit, square, bit-serial sqrt stages, divide stages.
// Depends on lav_pkg. Every stage advances only while en_i is high.
module lav_unit import lav_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  vec_t     vec_i [3],
  output unit_st_t st_o,
  output axis_t    axis_o [3]
);

  logic [VEC_W-1:0] amag [3];
  logic [VEC_W-1:0] amax;

  logic             a_v_q;
  logic [VEC_W-1:0] a_mag_q [3];
  logic             a_neg_q [3];
  logic [VEC_W-1:0] a_max_q;

  logic             b_v_q;
  logic [VEC_W-1:0] b_mag_q [3];
  logic             b_neg_q [3];
  logic [5:0]       b_pos_q;
  logic             b_nz_q;

  logic             c_v_q;
  logic [FIT_W-1:0] c_m_q [3];
  logic             c_neg_q [3];
  logic             c_ok_q;

  logic               d_v_q;
  logic [2*FIT_W-1:0] d_sq_q [3];
  logic [FIT_W-1:0]   d_m_q [3];
  logic               d_neg_q [3];
  logic               d_ok_q;

  logic                 sq_v_q    [ROOT_BITS+1];
  logic [VEC_W-1:0]     sq_rem_q  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] sq_root_q [ROOT_BITS+1];
  logic [FIT_W-1:0]     sq_m_q    [ROOT_BITS+1][3];
  logic                 sq_neg_q  [ROOT_BITS+1][3];
  logic                 sq_ok_q   [ROOT_BITS+1];

  logic                 dv_v_q   [ROOT_BITS+1];
  logic [VEC_W-1:0]     dv_rem_q [ROOT_BITS+1][3];
  logic [ROOT_BITS-1:0] dv_quo_q [ROOT_BITS+1][3];
  logic [ROOT_BITS-1:0] dv_len_q [ROOT_BITS+1];
  logic                 dv_neg_q [ROOT_BITS+1][3];
  logic                 dv_ok_q  [ROOT_BITS+1];

  logic  o_v_q;
  logic  o_ok_q;
  axis_t o_axis_q [3];

  always_comb begin
    amax = '0;
    for (int i = 0; i < 3; i++) begin
      amag[i] = mag64(vec_i[i]);
      if (amag[i] > amax) amax = amag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      d_v_q     <= 1'b0;
      sq_v_q[0] <= 1'b0;
      dv_v_q[0] <= 1'b0;
      o_v_q     <= 1'b0;
    end else if (en_i) begin
      a_v_q     <= valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      d_v_q     <= c_v_q;
      sq_v_q[0] <= d_v_q;
      dv_v_q[0] <= sq_v_q[ROOT_BITS];
      o_v_q     <= dv_v_q[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_max_q <= amax;
      b_pos_q <= msb_pos(a_max_q);
      b_nz_q  <= |a_max_q;
      c_ok_q  <= b_nz_q;
      d_ok_q  <= c_ok_q;
      sq_ok_q[0]   <= d_ok_q;
      sq_rem_q[0]  <= VEC_W'(d_sq_q[0]) + VEC_W'(d_sq_q[1]) + VEC_W'(d_sq_q[2]);
      sq_root_q[0] <= '0;
      dv_ok_q[0]   <= sq_ok_q[ROOT_BITS];
      dv_len_q[0]  <= sq_root_q[ROOT_BITS];
      o_ok_q       <= dv_ok_q[ROOT_BITS];
      for (int i = 0; i < 3; i++) begin
        a_mag_q[i] <= amag[i];
        a_neg_q[i] <= vec_i[i][VEC_W-1];
        b_mag_q[i] <= a_mag_q[i];
        b_neg_q[i] <= a_neg_q[i];
        c_m_q[i]   <= fit_mag(b_mag_q[i], b_pos_q);
        c_neg_q[i] <= b_neg_q[i];
        d_sq_q[i]  <= {{FIT_W{1'b0}}, c_m_q[i]} * {{FIT_W{1'b0}}, c_m_q[i]};
        d_m_q[i]   <= c_m_q[i];
        d_neg_q[i] <= c_neg_q[i];
        sq_m_q[0][i]   <= d_m_q[i];
        sq_neg_q[0][i] <= d_neg_q[i];
        // numerator with half the divisor added for rounding
        dv_rem_q[0][i] <= (VEC_W'(sq_m_q[ROOT_BITS][i]) << Q30_SH)
                          + VEC_W'(sq_root_q[ROOT_BITS] >> 1);
        dv_quo_q[0][i] <= '0;
        dv_neg_q[0][i] <= sq_neg_q[ROOT_BITS][i];
        if (!dv_ok_q[ROOT_BITS]) begin
          o_axis_q[i] <= '0;
        end else if (dv_neg_q[ROOT_BITS][i]) begin
          o_axis_q[i] <= -axis_t'({1'b0, dv_quo_q[ROOT_BITS][i]});
        end else begin
          o_axis_q[i] <= axis_t'({1'b0, dv_quo_q[ROOT_BITS][i]});
        end
      end
    end
  end

  // one root bit per stage, top bit first
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    localparam int B = ROOT_BITS - 1 - k;
    logic [VEC_W-1:0] trial;
    logic             take;
    assign trial = (VEC_W'(sq_root_q[k]) << (B + 1)) + (VEC_W'(1) << (2 * B));
    assign take  = sq_rem_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[k+1]  <= take ? sq_rem_q[k] - trial : sq_rem_q[k];
        sq_root_q[k+1] <= sq_root_q[k] | (take ? ROOT_BITS'(1) << B : '0);
        sq_m_q[k+1]    <= sq_m_q[k];
        sq_neg_q[k+1]  <= sq_neg_q[k];
        sq_ok_q[k+1]   <= sq_ok_q[k];
      end
    end
  end

  // one quotient bit per stage for all three components
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_div
    localparam int B = ROOT_BITS - 1 - k;
    logic [VEC_W-1:0] dvs;
    assign dvs = VEC_W'(dv_len_q[k]) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_len_q[k+1] <= dv_len_q[k];
        dv_ok_q[k+1]  <= dv_ok_q[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_q[k][i] >= dvs) begin
            dv_rem_q[k+1][i] <= dv_rem_q[k][i] - dvs;
            dv_quo_q[k+1][i] <= dv_quo_q[k][i] | (ROOT_BITS'(1) << B);
          end else begin
            dv_rem_q[k+1][i] <= dv_rem_q[k][i];
            dv_quo_q[k+1][i] <= dv_quo_q[k][i];
          end
        end
      end
    end
  end

  assign st_o.valid = o_v_q;
  assign st_o.ok    = o_ok_q;
  assign axis_o     = o_axis_q;

endmodule

[src/look_at_view_matrix_unit.sv]
// Top level of the look-at view matrix unit: forward and right normalizers, cross
// products, offset dot products and the three-row result sequencer.
// Depends on lav_pkg, lav_ifs and lav_unit.
//
//   channel  dir  width  word
//   cfg_i    in   34     up_dir register index and Q16.16 value
//   in_i     in   192    eye and aim points, Q16.16
//   out_o    out  140    one matrix row: axis Q2.30, offset Q23.16, flags
//
// A word passes s0, u_fwd, x1, x2, u_rgt, y1 to y3, o1, o2 and the row register
// before its first row; rows follow one per cycle while out_o is ready.
// The output sequencer sends three rows per word. The pipeline advances only when
// the row register is free or sends its last row, so a stall holds every stage.
// Reset clears all valid bits and loads the up_dir reset values.
module look_at_view_matrix_unit import lav_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lav_cfg_if.sink   cfg_i,
  lav_in_if.sink    in_i,
  lav_out_if.source out_o
);

  logic adv;

  // up_dir registers and their fitted copy
  coord_t           up_q [3];
  logic [VEC_W-1:0] up1_mag_q [3];
  logic             up1_neg_q [3];
  logic [VEC_W-1:0] up1_max_q;
  logic [VEC_W-1:0] up2_mag_q [3];
  logic             up2_neg_q [3];
  logic [5:0]       up2_pos_q;
  logic             up2_nz_q;
  axis_t            ups_q [3];
  logic             ups_ok_q;
  logic [VEC_W-1:0] upmag [3];
  logic [VEC_W-1:0] upmax;

  logic  s0_v_q;
  axis_t s0_eye_q [3];
  vec_t  s0_d_q [3];

  unit_st_t f_st;
  axis_t    f_ax [3];
  axis_t    dlf_eye_q [UNIT_LAT][3];

  logic  x1_v_q, x1_okf_q, x1_oku_q;
  axis_t x1_eye_q [3];
  axis_t x1_f_q [3];
  vec_t  x1_p_q [6];

  logic  x2_v_q, x2_okf_q, x2_okp_q;
  axis_t x2_eye_q [3];
  axis_t x2_f_q [3];
  vec_t  x2_c_q [3];

  unit_st_t r_st;
  axis_t    r_ax [3];
  axis_t    dlr_eye_q [UNIT_LAT][3];
  axis_t    dlr_f_q [UNIT_LAT][3];
  logic     dlr_okf_q [UNIT_LAT];
  logic     dlr_okp_q [UNIT_LAT];

  logic  y1_v_q, y1_okf_q, y1_okr_q;
  axis_t y1_eye_q [3];
  axis_t y1_f_q [3];
  axis_t y1_r_q [3];
  vec_t  y1_p_q [6];

  logic  y2_v_q, y2_okf_q, y2_okr_q;
  axis_t y2_eye_q [3];
  axis_t y2_f_q [3];
  axis_t y2_r_q [3];
  vec_t  y2_c_q [3];

  logic  y3_v_q, y3_okf_q, y3_okr_q;
  axis_t y3_eye_q [3];
  axis_t y3_f_q [3];
  axis_t y3_r_q [3];
  axis_t y3_u_q [3];
  vec_t  y2_t [3];
  axis_t y2_u [3];

  axis_t row_ax [3][3];
  logic  o1_v_q;
  axis_t o1_ax_q [3][3];
  logic  o1_deg_q [3];
  vec_t  o1_p_q [3][3];

  logic  o2_v_q;
  axis_t o2_ax_q [3][3];
  logic  o2_deg_q [3];
  vec_t  o2_dot_q [3];
  off_t  o2_off [3];

  logic  hold_v_q;
  row_e  row_q;
  axis_t hold_ax_q [3][3];
  logic  hold_deg_q [3];
  off_t  hold_off_q [3];

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= UP_X_RESET;
      up_q[1] <= UP_Y_RESET;
      up_q[2] <= UP_Z_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_UP_X: up_q[0] <= cfg_i.data;
        REG_UP_Y: up_q[1] <= cfg_i.data;
        REG_UP_Z: up_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    upmax = '0;
    for (int i = 0; i < 3; i++) begin
      upmag[i] = mag64(vec_t'(up_q[i]));
      if (upmag[i] > upmax) upmax = upmag[i];
    end
  end

  // up only sets a direction: fit it, never divide
  always_ff @(posedge clk_i) begin
    up1_max_q <= upmax;
    up2_pos_q <= msb_pos(up1_max_q);
    up2_nz_q  <= |up1_max_q;
    ups_ok_q  <= up2_nz_q;
    for (int i = 0; i < 3; i++) begin
      up1_mag_q[i] <= upmag[i];
      up1_neg_q[i] <= up_q[i][COORD_W-1];
      up2_mag_q[i] <= up1_mag_q[i];
      up2_neg_q[i] <= up1_neg_q[i];
      ups_q[i]     <= up2_neg_q[i] ? -axis_t'(fit_mag(up2_mag_q[i], up2_pos_q))
                                   :  axis_t'(fit_mag(up2_mag_q[i], up2_pos_q));
    end
  end

  // ---------------- pipeline control ----------------
  assign adv        = !hold_v_q || (out_o.ready && row_q == ROW_FWD);
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      x1_v_q <= 1'b0;
      x2_v_q <= 1'b0;
      y1_v_q <= 1'b0;
      y2_v_q <= 1'b0;
      y3_v_q <= 1'b0;
      o1_v_q <= 1'b0;
      o2_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_i.valid;
      x1_v_q <= f_st.valid;
      x2_v_q <= x1_v_q;
      y1_v_q <= r_st.valid;
      y2_v_q <= y1_v_q;
      y3_v_q <= y2_v_q;
      o1_v_q <= y3_v_q;
      o2_v_q <= o1_v_q;
    end
  end

  // ---------------- forward axis ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_eye_q[0] <= in_i.eye_x;
      s0_eye_q[1] <= in_i.eye_y;
      s0_eye_q[2] <= in_i.eye_z;
      s0_d_q[0]   <= vec_t'(in_i.eye_x) - vec_t'(in_i.aim_x);
      s0_d_q[1]   <= vec_t'(in_i.eye_y) - vec_t'(in_i.aim_y);
      s0_d_q[2]   <= vec_t'(in_i.eye_z) - vec_t'(in_i.aim_z);
    end
  end

  lav_unit u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s0_v_q),
    .vec_i   (s0_d_q),
    .st_o    (f_st),
    .axis_o  (f_ax)
  );

  // carry eye alongside the normalizer
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlf_eye_q[0] <= s0_eye_q;
      for (int k = 1; k < UNIT_LAT; k++) dlf_eye_q[k] <= dlf_eye_q[k-1];
    end
  end

  // ---------------- right axis: up cross forward ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_eye_q <= dlf_eye_q[UNIT_LAT-1];
      x1_f_q   <= f_ax;
      x1_okf_q <= f_st.ok;
      x1_oku_q <= ups_ok_q;
      x1_p_q[0] <= smul(ups_q[1], f_ax[2]);
      x1_p_q[1] <= smul(ups_q[2], f_ax[1]);
      x1_p_q[2] <= smul(ups_q[2], f_ax[0]);
      x1_p_q[3] <= smul(ups_q[0], f_ax[2]);
      x1_p_q[4] <= smul(ups_q[0], f_ax[1]);
      x1_p_q[5] <= smul(ups_q[1], f_ax[0]);

      x2_eye_q <= x1_eye_q;
      x2_f_q   <= x1_f_q;
      x2_okf_q <= x1_okf_q;
      x2_okp_q <= x1_okf_q && x1_oku_q;
      x2_c_q[0] <= x1_p_q[0] - x1_p_q[1];
      x2_c_q[1] <= x1_p_q[2] - x1_p_q[3];
      x2_c_q[2] <= x1_p_q[4] - x1_p_q[5];
    end
  end

  lav_unit u_rgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (x2_v_q),
    .vec_i   (x2_c_q),
    .st_o    (r_st),
    .axis_o  (r_ax)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlr_eye_q[0] <= x2_eye_q;
      dlr_f_q[0]   <= x2_f_q;
      dlr_okf_q[0] <= x2_okf_q;
      dlr_okp_q[0] <= x2_okp_q;
      for (int k = 1; k < UNIT_LAT; k++) begin
        dlr_eye_q[k] <= dlr_eye_q[k-1];
        dlr_f_q[k]   <= dlr_f_q[k-1];
        dlr_okf_q[k] <= dlr_okf_q[k-1];
        dlr_okp_q[k] <= dlr_okp_q[k-1];
      end
    end
  end

  // ---------------- true up: forward cross right ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y2_t[i] = (y2_c_q[i] + Q30_HALF) >>> Q30_SH;
      if (y2_t[i] > Q30_ONE)       y2_u[i] = axis_t'(Q30_ONE);
      else if (y2_t[i] < -Q30_ONE) y2_u[i] = axis_t'(-Q30_ONE);
      else                         y2_u[i] = axis_t'(y2_t[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y1_eye_q <= dlr_eye_q[UNIT_LAT-1];
      y1_f_q   <= dlr_f_q[UNIT_LAT-1];
      y1_r_q   <= r_ax;
      y1_okf_q <= dlr_okf_q[UNIT_LAT-1];
      y1_okr_q <= dlr_okp_q[UNIT_LAT-1] && r_st.ok;
      y1_p_q[0] <= smul(dlr_f_q[UNIT_LAT-1][1], r_ax[2]);
      y1_p_q[1] <= smul(dlr_f_q[UNIT_LAT-1][2], r_ax[1]);
      y1_p_q[2] <= smul(dlr_f_q[UNIT_LAT-1][2], r_ax[0]);
      y1_p_q[3] <= smul(dlr_f_q[UNIT_LAT-1][0], r_ax[2]);
      y1_p_q[4] <= smul(dlr_f_q[UNIT_LAT-1][0], r_ax[1]);
      y1_p_q[5] <= smul(dlr_f_q[UNIT_LAT-1][1], r_ax[0]);

      y2_eye_q <= y1_eye_q;
      y2_f_q   <= y1_f_q;
      y2_r_q   <= y1_r_q;
      y2_okf_q <= y1_okf_q;
      y2_okr_q <= y1_okr_q;
      y2_c_q[0] <= y1_p_q[0] - y1_p_q[1];
      y2_c_q[1] <= y1_p_q[2] - y1_p_q[3];
      y2_c_q[2] <= y1_p_q[4] - y1_p_q[5];

      y3_eye_q <= y2_eye_q;
      y3_f_q   <= y2_f_q;
      y3_r_q   <= y2_r_q;
      y3_u_q   <= y2_u;
      y3_okf_q <= y2_okf_q;
      y3_okr_q <= y2_okr_q;
    end
  end

  // ---------------- offsets ----------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_ax[ROW_RIGHT][i] = y3_okr_q ? y3_r_q[i] : '0;
      row_ax[ROW_UP][i]    = y3_okr_q ? y3_u_q[i] : '0;
      row_ax[ROW_FWD][i]   = y3_okf_q ? y3_f_q[i] : '0;
    end
  end

  // negate the rounded dot and saturate to the offset range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (-o2_dot_q[k] > OFF_MAX)      o2_off[k] = off_t'(OFF_MAX);
      else if (-o2_dot_q[k] < OFF_MIN) o2_off[k] = off_t'(OFF_MIN);
      else                             o2_off[k] = off_t'(-o2_dot_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o1_ax_q        <= row_ax;
      o1_deg_q[ROW_RIGHT] <= !y3_okr_q;
      o1_deg_q[ROW_UP]    <= !y3_okr_q;
      o1_deg_q[ROW_FWD]   <= !y3_okf_q;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          o1_p_q[k][i] <= smul(row_ax[k][i], y3_eye_q[i]);
        end
      end

      o2_ax_q  <= o1_ax_q;
      o2_deg_q <= o1_deg_q;
      for (int k = 0; k < 3; k++) begin
        o2_dot_q[k] <= (o1_p_q[k][0] + o1_p_q[k][1] + o1_p_q[k][2] + Q30_HALF) >>> Q30_SH;
      end

      hold_ax_q  <= o2_ax_q;
      hold_deg_q <= o2_deg_q;
      hold_off_q <= o2_off;
    end
  end

  // ---------------- row sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      row_q    <= ROW_RIGHT;
    end else if (adv) begin
      hold_v_q <= o2_v_q;
      row_q    <= ROW_RIGHT;
    end else if (out_o.ready) begin
      case (row_q)
        ROW_RIGHT: row_q <= ROW_UP;
        ROW_UP:    row_q <= ROW_FWD;
        default:   row_q <= ROW_RIGHT;
      endcase
    end
  end

  always_comb begin
    out_o.valid     = hold_v_q;
    out_o.row_index = row_q;
    out_o.last_row  = row_q == ROW_FWD;
    case (row_q)
      ROW_RIGHT: begin
        out_o.axis_x     = hold_ax_q[ROW_RIGHT][0];
        out_o.axis_y     = hold_ax_q[ROW_RIGHT][1];
        out_o.axis_z     = hold_ax_q[ROW_RIGHT][2];
        out_o.offset     = hold_off_q[ROW_RIGHT];
        out_o.degenerate = hold_deg_q[ROW_RIGHT];
      end
      ROW_UP: begin
        out_o.axis_x     = hold_ax_q[ROW_UP][0];
        out_o.axis_y     = hold_ax_q[ROW_UP][1];
        out_o.axis_z     = hold_ax_q[ROW_UP][2];
        out_o.offset     = hold_off_q[ROW_UP];
        out_o.degenerate = hold_deg_q[ROW_UP];
      end
      default: begin
        out_o.axis_x     = hold_ax_q[ROW_FWD][0];
        out_o.axis_y     = hold_ax_q[ROW_FWD][1];
        out_o.axis_z     = hold_ax_q[ROW_FWD][2];
        out_o.offset     = hold_off_q[ROW_FWD];
        out_o.degenerate = hold_deg_q[ROW_FWD];
      end
    endcase
  end

  // ---------------- assertions ----------------
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && row_q == ROW_FWD) |=> (row_q == ROW_RIGHT))
    else $error("row sequence did not restart after the last row");

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.degenerate) |->
      (out_o.axis_x == '0 && out_o.axis_y == '0 && out_o.axis_z == '0 &&
       out_o.offset == '0))
    else $error("degenerate row carries nonzero data");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.degenerate) |->
      (out_o.axis_x <= axis_t'(Q30_ONE) && out_o.axis_x >= -axis_t'(Q30_ONE) &&
       out_o.axis_y <= axis_t'(Q30_ONE) && out_o.axis_y >= -axis_t'(Q30_ONE) &&
       out_o.axis_z <= axis_t'(Q30_ONE) && out_o.axis_z >= -axis_t'(Q30_ONE)))
    else $error("axis component exceeds unit magnitude");

endmodule
